[design/tpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types, register indexes and pixel mode codes for the pixel converter.
// ----------------------------------------------------------------------------
package tpr_pkg;

  // Pixel modes held in the pixel_mode register.
  typedef enum logic [1:0] {
    MODE_4BPP  = 2'd0,
    MODE_8BPP  = 2'd1,
    MODE_16BPP = 2'd2,
    MODE_CLUT  = 2'd3
  } pixel_mode_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_PIXEL_MODE = 1'b0,
    REG_INDEXED    = 1'b1
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0]  GREEN_KEY    = 8'd248;

  // Position of the nibble inside a four-bit-mode word.
  typedef logic [1:0] nib_sel_t;
  localparam nib_sel_t NIB_LAST = 2'd3;

  // One finished RGBA pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  // Register settings seen by the datapath.
  typedef struct packed {
    pixel_mode_t mode;
    logic        indexed;
  } cfg_t;

endpackage

[design/tpr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_if
// Handshake channels: input data words, output pixels and register writes.
// ----------------------------------------------------------------------------
interface tpr_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface tpr_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last;
  modport source (output valid, output red, output green, output blue,
                  output alpha, output last, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, input last, output ready);
endinterface

interface tpr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic                            index;
  logic [tpr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/tpr_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_decode
// Turns the selected part of a data word into one RGBA pixel.
// ----------------------------------------------------------------------------
module tpr_decode (
  input  logic [15:0]         word,
  input  tpr_pkg::nib_sel_t   nib_sel,
  input  tpr_pkg::cfg_t       cfg,
  output tpr_pkg::pixel_t     pixel
);

  logic [3:0]  nibble;
  logic [7:0]  index;
  logic [15:0] colour;
  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic        table_entry;
  logic        use_index;

  // Pick the nibble for four-bit mode, low nibble first.
  assign nibble = word[{nib_sel, 2'b00} +: 4];

  // Widen the index to a colour word by repeating it; in 16 bit and table entry modes the word is used as is.
  always_comb begin
    case (cfg.mode)
      tpr_pkg::MODE_4BPP: begin
        index  = {4'd0, nibble};
        colour = {nibble, nibble, nibble, nibble};
      end
      tpr_pkg::MODE_8BPP: begin
        index  = word[7:0];
        colour = {word[7:0], word[7:0]};
      end
      default: begin
        index  = word[7:0];
        colour = word;
      end
    endcase
  end

  assign table_entry = (cfg.mode == tpr_pkg::MODE_CLUT);
  assign use_index   = cfg.indexed &&
                       ((cfg.mode == tpr_pkg::MODE_4BPP) || (cfg.mode == tpr_pkg::MODE_8BPP));

  // Decode the 5-5-5 word, red in the low bits.
  assign r = {colour[4:0], 3'b000};
  assign g = {colour[9:5], 3'b000};
  assign b = {colour[14:10], 3'b000};

  // Build the pixel; the last flag is set by the caller.
  always_comb begin
    pixel.last = 1'b0;
    if (use_index) begin
      pixel.red   = index;
      pixel.green = 8'd0;
      pixel.blue  = 8'd0;
      pixel.alpha = tpr_pkg::ALPHA_OPAQUE;
    end else if (table_entry) begin
      pixel.red   = r;
      pixel.green = g;
      pixel.blue  = b;
      pixel.alpha = tpr_pkg::ALPHA_OPAQUE;
    end else begin
      pixel.red   = r;
      pixel.blue  = b;
      // Pure key green is shown as black.
      if ((r == 8'd0) && (g == tpr_pkg::GREEN_KEY) && (b == 8'd0)) begin
        pixel.green = 8'd0;
      end else begin
        pixel.green = g;
      end
      pixel.alpha = colour[15] ? tpr_pkg::ALPHA_CLEAR : tpr_pkg::ALPHA_OPAQUE;
    end
  end

endmodule

[design/tpr_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_stage
// Input register that holds one data word and steps through its pixels.
// ----------------------------------------------------------------------------
module tpr_stage (
  input  logic              clk,
  input  logic              rst,
  tpr_word_if.sink          data_in,
  input  tpr_pkg::cfg_t     cfg,
  input  logic              advance_ok,
  output logic              hold_valid,
  output logic              hold_last,
  output logic [15:0]       hold_word,
  output tpr_pkg::nib_sel_t nib_sel
);

  logic              valid;
  logic [15:0]       word;
  tpr_pkg::nib_sel_t cnt;
  logic              advance;

  // The current pixel is the final one of the word.
  assign hold_last = (cfg.mode != tpr_pkg::MODE_4BPP) || (cnt == tpr_pkg::NIB_LAST);
  assign advance   = valid && advance_ok;

  // A new word enters when the register is empty or its final pixel moves on.
  assign data_in.ready = !valid || (advance && hold_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (data_in.valid && data_in.ready) begin
      valid <= 1'b1;
      cnt   <= '0;
    end else if (advance && hold_last) begin
      valid <= 1'b0;
    end else if (advance) begin
      cnt <= cnt + 2'd1;
    end
  end

  // Word payload needs no reset.
  always_ff @(posedge clk) begin
    if (data_in.valid && data_in.ready) begin
      word <= data_in.data_word;
    end
  end

  assign hold_valid = valid;
  assign hold_word  = word;
  assign nib_sel    = cnt;

endmodule

[design/tim_pixel_to_rgba.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tim_pixel_to_rgba
// Converts 4, 8 and 16 bit image data and colour table entries to RGBA8888.
// ----------------------------------------------------------------------------
// Path: input register, decode, output register. While pixel_out.ready holds,
// one pixel per cycle out and one word per cycle in 8 bit, 16 bit and table
// entry modes; in four-bit mode the next word is taken only as the fourth
// pixel of the word moves on.
// Reset: pixel_mode returns to sixteen bits, indexed to 0, both stages empty.
module tim_pixel_to_rgba (
  input  logic        clk,
  input  logic        rst,
  tpr_word_if.sink    data_in,
  tpr_pixel_if.source pixel_out,
  tpr_cfg_if.sink     cfg
);

  tpr_pkg::cfg_t     cfg_q;
  logic              out_valid;
  tpr_pkg::pixel_t   out_pixel;
  logic              out_free;
  logic              hold_valid;
  logic              hold_last;
  logic [15:0]       hold_word;
  tpr_pkg::nib_sel_t nib_sel;
  tpr_pkg::pixel_t   dec_pixel;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.mode    <= tpr_pkg::MODE_16BPP;
      cfg_q.indexed <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tpr_pkg::REG_PIXEL_MODE: cfg_q.mode    <= tpr_pkg::pixel_mode_t'(cfg.data);
        tpr_pkg::REG_INDEXED:    cfg_q.indexed <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Output register can take a pixel when empty or being drained.
  assign out_free = !out_valid || pixel_out.ready;

  tpr_stage u_stage (
    .clk        (clk),
    .rst        (rst),
    .data_in    (data_in),
    .cfg        (cfg_q),
    .advance_ok (out_free),
    .hold_valid (hold_valid),
    .hold_last  (hold_last),
    .hold_word  (hold_word),
    .nib_sel    (nib_sel)
  );

  tpr_decode u_decode (
    .word    (hold_word),
    .nib_sel (nib_sel),
    .cfg     (cfg_q),
    .pixel   (dec_pixel)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && hold_valid) begin
      out_pixel <= '{red: dec_pixel.red, green: dec_pixel.green, blue: dec_pixel.blue,
                     alpha: dec_pixel.alpha, last: hold_last};
    end
  end

  assign pixel_out.valid = out_valid;
  assign pixel_out.red   = out_pixel.red;
  assign pixel_out.green = out_pixel.green;
  assign pixel_out.blue  = out_pixel.blue;
  assign pixel_out.alpha = out_pixel.alpha;
  assign pixel_out.last  = out_pixel.last;

endmodule
